/* hdl/gaussian_bayes_band_fusion_core_assert.svh */
// assertion macros for the fusion core
`ifndef GAUSSIAN_BAYES_BAND_FUSION_CORE_ASSERT_SVH
`define GAUSSIAN_BAYES_BAND_FUSION_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define GBBF_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gbbf assertion failed");

// next-cycle implication, checked outside reset
`define GBBF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gbbf assertion failed");

`endif

/* hdl/gbbf_pkg.sv */
package gbbf_pkg;

  // field widths
  localparam int SAMPLE_W  = 16;
  localparam int BAND_W    = 2;
  localparam int TIME_W    = 8;
  localparam int PROB_W    = 17;
  localparam int MODEL_W   = 32;
  localparam int HALF_W    = 16;
  localparam int NUM_MODELS = 8;
  localparam int CFG_IDX_W = 3;
  localparam int MAX_TIMES = 256;
  localparam int MAX_BANDS = 4;

  // register index bases of the two model groups
  localparam logic [CFG_IDX_W-1:0] FOREST_BASE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] NF_BASE     = 3'd4;

  // probability constants in Q16
  localparam logic [PROB_W-1:0] ONE_Q16  = 17'd65536;
  localparam logic [PROB_W-1:0] HALF_Q16 = 17'd32768;

  // density datapath
  localparam int Z_W       = 32;
  localparam int Z_LIM_W   = 19;
  localparam int Q_W       = 21;
  localparam int ACC_W     = 33;
  localparam int G_W       = 32;
  localparam int DENS_W    = 40;
  localparam int EXP_STEPS = 21;
  localparam int DENS_LAT  = 3 + EXP_STEPS + 2;
  localparam logic [ACC_W-1:0]  ACC_ONE      = 33'h1_0000_0000;
  localparam logic [30:0]       INV_SQRT_2PI = 31'd1713444050;
  localparam logic [DENS_W-1:0] NF_MIN       = 40'd42950;

  // exp(-w) in Q0.32 for weights 1/2 .. 1/65536, then 1, 2, 4, 8, 16
  localparam logic [31:0] EXP_TAB [EXP_STEPS] = '{
    32'd2605029347, 32'd3344923893, 32'd3790295335, 32'd4034748382,
    32'd4162825044, 32'd4228380000, 32'd4261543595, 32'd4278222805,
    32'd4286595067, 32'd4290775039, 32'd4292870656, 32'd4293918848,
    32'd4294443040, 32'd4294705160, 32'd4294836226, 32'd4294901760,
    32'd1580030169, 32'd581260615,  32'd78665071,   32'd1440801,
    32'd483
  };

  // bit of q that enables exp step k
  function automatic int exp_bit(int k);
    return (k < 16) ? (15 - k) : k;
  endfunction

  // divider
  localparam int DIV_STEPS = PROB_W;
  localparam int DEN_W     = 40;
  localparam int BAYES_W   = 33;

  // item tag that travels beside the data
  typedef struct packed {
    logic              valid;
    logic [BAND_W-1:0] band;
    logic [TIME_W-1:0] tidx;
    logic              last;
    logic              ovr;
    logic [PROB_W-1:0] p;
  } tag_t;

endpackage

/* hdl/gbbf_density.sv */
module gbbf_density (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [gbbf_pkg::SAMPLE_W-1:0] x,
  input  logic [gbbf_pkg::MODEL_W-1:0]        model,
  output logic [gbbf_pkg::DENS_W-1:0]         dens
);
  import gbbf_pkg::*;

  logic signed [SAMPLE_W-1:0] mean;
  logic signed [SAMPLE_W:0]   diff;
  logic [SAMPLE_W:0]          mag;
  logic [SAMPLE_W-1:0]        ad1;
  logic [HALF_W-1:0]          r1, r2, r3;
  logic [Z_W-1:0]             z2;
  logic [2*Z_LIM_W-1:0]       sq;
  logic [Q_W-1:0]             q3;
  logic                       big3;

  logic [ACC_W-1:0]  acc [EXP_STEPS];
  logic [Q_W-1:0]    qv  [EXP_STEPS];
  logic              bg  [EXP_STEPS];
  logic [HALF_W-1:0] rv  [EXP_STEPS];

  logic [ACC_W+30:0]      prod_g;
  logic [G_W-1:0]         g;
  logic [HALF_W-1:0]      rg;
  logic [G_W+HALF_W-1:0]  prod_n;

  // distance to the mean
  assign mean = model[SAMPLE_W-1:0];
  assign diff = {x[SAMPLE_W-1], x} - {mean[SAMPLE_W-1], mean};
  assign mag  = diff[SAMPLE_W] ? (~diff + 1'b1) : diff;
  assign sq   = z2[Z_LIM_W-1:0] * z2[Z_LIM_W-1:0];

  // front stages: |d|, z = |d| * r, q = z^2 / 2
  always_ff @(posedge clk) begin
    if (en) begin
      ad1  <= mag[SAMPLE_W-1:0];
      r1   <= model[MODEL_W-1:HALF_W];
      z2   <= ad1 * r1;
      r2   <= r1;
      q3   <= sq[2*Z_LIM_W-1:17];
      big3 <= |z2[Z_W-1:Z_LIM_W];
      r3   <= r2;
    end
  end

  // one table multiply per stage for exp(-q)
  for (genvar k = 0; k < EXP_STEPS; k++) begin : g_exp
    localparam int BIT = exp_bit(k);
    logic [ACC_W-1:0]  a_in;
    logic [Q_W-1:0]    q_in;
    logic              b_in;
    logic [HALF_W-1:0] r_in;
    logic [ACC_W+31:0] prod;

    if (k == 0) begin : g_first
      assign a_in = ACC_ONE;
      assign q_in = q3;
      assign b_in = big3;
      assign r_in = r3;
    end else begin : g_next
      assign a_in = acc[k-1];
      assign q_in = qv[k-1];
      assign b_in = bg[k-1];
      assign r_in = rv[k-1];
    end

    assign prod = a_in * EXP_TAB[k];

    always_ff @(posedge clk) begin
      if (en) begin
        acc[k] <= q_in[BIT] ? prod[ACC_W+31:32] : a_in;
        qv[k]  <= q_in;
        bg[k]  <= b_in;
        rv[k]  <= r_in;
      end
    end
  end

  // scale by 1/sqrt(2 pi), then by r
  assign prod_g = acc[EXP_STEPS-1] * INV_SQRT_2PI;
  assign prod_n = g * rg;

  always_ff @(posedge clk) begin
    if (en) begin
      g    <= bg[EXP_STEPS-1] ? '0 : prod_g[ACC_W+30:32];
      rg   <= rv[EXP_STEPS-1];
      dens <= prod_n[G_W+HALF_W-1:8];
    end
  end

endmodule

/* hdl/gbbf_divider.sv */
module gbbf_divider (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic [gbbf_pkg::DEN_W-1:0]   num,
  input  logic [gbbf_pkg::DEN_W-1:0]   den,
  input  gbbf_pkg::tag_t               tag_in,
  output logic [gbbf_pkg::PROB_W-1:0]  quo,
  output gbbf_pkg::tag_t               tag_out,
  output gbbf_pkg::tag_t               tags [gbbf_pkg::DIV_STEPS]
);
  import gbbf_pkg::*;

  // restoring division of num * 2^16 by den, num <= den, one bit per stage
  logic [DEN_W-1:0]  rem [DIV_STEPS];
  logic [DEN_W-1:0]  dn  [DIV_STEPS];
  logic [PROB_W-1:0] qq  [DIV_STEPS];
  tag_t              tg  [DIV_STEPS];

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
    logic [DEN_W:0]    rem_s;
    logic [DEN_W:0]    sub;
    logic [DEN_W-1:0]  d_in;
    logic [PROB_W-1:0] q_in;
    tag_t              t_in;
    logic              ge;

    if (j == 0) begin : g_first
      assign rem_s = {1'b0, num};
      assign d_in  = den;
      assign q_in  = '0;
      assign t_in  = tag_in;
    end else begin : g_next
      assign rem_s = {rem[j-1], 1'b0};
      assign d_in  = dn[j-1];
      assign q_in  = qq[j-1];
      assign t_in  = tg[j-1];
    end

    assign sub = rem_s - {1'b0, d_in};
    assign ge  = rem_s >= {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[j] <= ge ? sub[DEN_W-1:0] : rem_s[DEN_W-1:0];
        dn[j]  <= d_in;
        qq[j]  <= {q_in[PROB_W-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        tg[j] <= '0;
      end else if (en) begin
        tg[j] <= t_in;
      end
    end
  end

  assign quo     = qq[DIV_STEPS-1];
  assign tag_out = tg[DIV_STEPS-1];
  assign tags    = tg;

endmodule

/* hdl/gaussian_bayes_band_fusion_core.sv */
// Two-class Gaussian band fusion. Each input item (sample, band, time) yields one
// result item: the non-forest probability in Q16 (65536 is one) fused over the bands
// seen so far for that time slot. Band 0 starts the slot, later bands fuse with it.
// One item is taken per cycle unless back-pressure or a slot hazard stalls it. Path:
// input register, 26-stage density pipeline with one exp table multiply per exp
// stage, two 17-stage restoring dividers, three fusion registers, output register. A
// nonzero band whose time slot still has an item between the slot memory read and its
// write-back (19 stages) waits at the fusion entry until that item has written the
// slot. Model registers may be written only while the block is idle.
`include "gaussian_bayes_band_fusion_core_assert.svh"

module gaussian_bayes_band_fusion_core (
  input  logic                            clk,
  input  logic                            rst,
  // configuration writes
  input  logic                            cfg_we,
  input  logic [gbbf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gbbf_pkg::MODEL_W-1:0]    cfg_data,
  // input items
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [23:0]                     s_tdata,  // sample[15:0], time_index[23:16]
  input  logic [gbbf_pkg::BAND_W-1:0]     s_tuser,  // band[1:0]
  input  logic                            s_tlast,  // last_band
  // result items
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [31:0]                     m_tdata,  // nonforest_prob[16:0], time_out[24:17]
  output logic                            m_tlast   // final_res
);
  import gbbf_pkg::*;

  logic [MODEL_W-1:0] model [NUM_MODELS];

  logic adv, adv_f, hazard;

  tag_t                       in_tag, in_next;
  logic signed [SAMPLE_W-1:0] in_x;
  logic [CFG_IDX_W-1:0]       f_idx, nf_idx;
  logic [DENS_W-1:0]          f_dens, nf_dens;
  tag_t                       dline [DENS_LAT];

  tag_t              d1_in, d1_out, f0_tag, f1_tag, f2_tag, d2_in, d2_out;
  tag_t              f0_next, f1_next;
  tag_t              d1_tags [DIV_STEPS];
  tag_t              d2_tags [DIV_STEPS];
  logic [PROB_W-1:0] d1_quo, d2_quo;

  logic [PROB_W-1:0]  mem [MAX_TIMES];
  logic [PROB_W-1:0]  rd, prior, not_prior, not_p;
  logic [2*PROB_W-1:0] a_full, b_full;
  logic [BAYES_W-1:0] a2, b2;
  logic [BAYES_W:0]   sum2;
  logic [PROB_W-1:0]  res;

  logic [PROB_W-1:0] out_prob;
  logic [TIME_W-1:0] out_time;
  logic              out_last;

  // model registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_MODELS; i++) model[i] <= '0;
    end else if (cfg_we) begin
      model[cfg_index] <= cfg_data;
    end
  end

  // stall control: back half moves when the output register frees up,
  // front half also waits on a time slot still in the fusion section
  assign adv      = !m_tvalid || m_tready;
  assign adv_f    = adv && !hazard;
  assign s_tready = adv_f;

  always_comb begin
    hazard = f1_tag.valid && (f1_tag.tidx == f0_tag.tidx);
    hazard = hazard || (f2_tag.valid && (f2_tag.tidx == f0_tag.tidx));
    for (int i = 0; i < DIV_STEPS; i++) begin
      hazard = hazard || (d2_tags[i].valid && (d2_tags[i].tidx == f0_tag.tidx));
    end
    hazard = hazard && f0_tag.valid && (f0_tag.band != '0);
  end

  // input register
  always_comb begin
    in_next       = '0;
    in_next.valid = s_tvalid;
    in_next.band  = s_tuser;
    in_next.tidx  = s_tdata[23:16];
    in_next.last  = s_tlast;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_tag <= '0;
    end else if (adv_f) begin
      in_tag <= in_next;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_f) begin
      in_x <= s_tdata[SAMPLE_W-1:0];
    end
  end

  // band models, all four bands present so no saturation is needed
  assign f_idx  = FOREST_BASE + {1'b0, in_tag.band};
  assign nf_idx = NF_BASE + {1'b0, in_tag.band};

  gbbf_density u_forest (
    .clk   (clk),
    .en    (adv_f),
    .x     (in_x),
    .model (model[f_idx]),
    .dens  (f_dens)
  );

  gbbf_density u_nonforest (
    .clk   (clk),
    .en    (adv_f),
    .x     (in_x),
    .model (model[nf_idx]),
    .dens  (nf_dens)
  );

  // tags beside the density pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DENS_LAT; i++) dline[i] <= '0;
    end else if (adv_f) begin
      dline[0] <= in_tag;
      for (int i = 1; i < DENS_LAT; i++) dline[i] <= dline[i-1];
    end
  end

  // p = nf / (nf + f), zero when nf is below the floor
  always_comb begin
    d1_in     = dline[DENS_LAT-1];
    d1_in.ovr = nf_dens < NF_MIN;
  end

  gbbf_divider u_div_p (
    .clk     (clk),
    .rst     (rst),
    .en      (adv_f),
    .num     (nf_dens),
    .den     (nf_dens + f_dens),
    .tag_in  (d1_in),
    .quo     (d1_quo),
    .tag_out (d1_out),
    .tags    (d1_tags)
  );

  // fusion entry
  always_comb begin
    f0_next   = d1_out;
    f0_next.p = d1_out.ovr ? '0 : d1_quo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f0_tag <= '0;
    end else if (adv_f) begin
      f0_tag <= f0_next;
    end
  end

  // slot read, bubble while the slot is still in flight
  always_comb begin
    f1_next       = f0_tag;
    f1_next.valid = f0_tag.valid && !hazard;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_tag <= '0;
      f2_tag <= '0;
    end else if (adv) begin
      f1_tag <= f1_next;
      f2_tag <= f1_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rd <= mem[f0_tag.tidx];
    end
  end

  // Bayes terms
  assign prior     = (rd > ONE_Q16) ? ONE_Q16 : rd;
  assign not_prior = ONE_Q16 - prior;
  assign not_p     = ONE_Q16 - f1_tag.p;
  assign a_full    = prior * f1_tag.p;
  assign b_full    = not_prior * not_p;

  always_ff @(posedge clk) begin
    if (adv) begin
      a2 <= a_full[BAYES_W-1:0];
      b2 <= b_full[BAYES_W-1:0];
    end
  end

  assign sum2 = {1'b0, a2} + {1'b0, b2};

  always_comb begin
    d2_in     = f2_tag;
    d2_in.ovr = sum2 == '0;
  end

  gbbf_divider u_div_fuse (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .num     ({{(DEN_W-BAYES_W){1'b0}}, a2}),
    .den     ({{(DEN_W-BAYES_W-1){1'b0}}, sum2}),
    .tag_in  (d2_in),
    .quo     (d2_quo),
    .tag_out (d2_out),
    .tags    (d2_tags)
  );

  // band 0 keeps its own p, both terms zero gives one half
  always_comb begin
    if (d2_out.band == '0) begin
      res = d2_out.p;
    end else if (d2_out.ovr) begin
      res = HALF_Q16;
    end else begin
      res = d2_quo;
    end
  end

  // slot write-back
  always_ff @(posedge clk) begin
    if (adv && d2_out.valid) begin
      mem[d2_out.tidx] <= res;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= d2_out.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_prob <= res;
      out_time <= d2_out.tidx;
      out_last <= d2_out.last;
    end
  end

  assign m_tdata = {{(32-PROB_W-TIME_W){1'b0}}, out_time, out_prob};
  assign m_tlast = out_last;

  // checks
  `GBBF_ASSERT_NEXT(a_hazard_bubble, hazard && adv, !f1_tag.valid)
  `GBBF_ASSERT_NEXT(a_entry_hold, f0_tag.valid && !adv_f, f0_tag.valid && $stable(f0_tag.tidx))
  `GBBF_ASSERT_IMPLY(a_out_source, $rose(m_tvalid), $past(d2_out.valid))

endmodule
